// File: hw/rtl/sas_pkg.sv
// Package of the sprite animation sequencer: frame entry and track record
// types, request kinds, flag bits, controller states and default sizes.
// No dependencies.
package sas_pkg;

  localparam int TRACKS_DEF         = 32;
  localparam int FRAMES_DEF         = 256;
  localparam int END_HOLD_DEF       = 10;
  localparam int LEN_W              = 9;   // track length reaches 256
  localparam int TRIG_W             = 16;

  localparam int FLAG_WAIT_BIT    = 3;
  localparam int FLAG_HALT_BIT    = 4;
  localparam int FLAG_HOLD_BIT    = 5;
  localparam int FLAG_RESET_Y_BIT = 6;
  localparam int FLAG_RESET_X_BIT = 7;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_START = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_RD,
    ST_REP,
    ST_ADV
  } state_t;

  typedef struct packed {
    logic [15:0] trig_set;
    logic [15:0] move_y;
    logic [15:0] move_x;
    logic [7:0]  loop_target;
    logic [7:0]  loop_count;
    logic        loop_enable;
    logic [7:0]  flags;
    logic [7:0]  delay;
    logic [7:0]  image;
  } frame_entry_t;

  typedef struct packed {
    logic [7:0]       frame;
    logic [LEN_W-1:0] len;
    logic [7:0]       loop_cnt;
    logic [7:0]       wait_cnt;
    logic [15:0]      pos_x;
    logic [15:0]      pos_y;
  } track_t;

endpackage

// File: hw/rtl/sas_if.sv
// Channel interfaces of the sprite animation sequencer: request input,
// report output and the track count write port. Depends on nothing.
interface sas_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [4:0]  track;
  logic [7:0]  index;
  logic [7:0]  image;
  logic [7:0]  delay;
  logic [7:0]  flags;
  logic signed [15:0] move_x;
  logic signed [15:0] move_y;
  logic        loop_enable;
  logic [7:0]  loop_count;
  logic [7:0]  loop_target;
  logic [15:0] trig_set;
  modport source (output valid, kind, track, index, image, delay, flags, move_x, move_y,
                  loop_enable, loop_count, loop_target, trig_set, input ready);
  modport sink (input valid, kind, track, index, image, delay, flags, move_x, move_y,
                loop_enable, loop_count, loop_target, trig_set, output ready);
endinterface

interface sas_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  track_out;
  logic [7:0]  image_out;
  logic signed [15:0] offset_x;
  logic signed [15:0] offset_y;
  logic        visible;
  logic        any_running;
  logic        last;
  modport source (output valid, track_out, image_out, offset_x, offset_y, visible,
                  any_running, last, input ready);
  modport sink (input valid, track_out, image_out, offset_x, offset_y, visible,
                any_running, last, output ready);
endinterface

interface sas_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: hw/rtl/sas_frame_mem.sv
// Frame entry memory: one write port, one read port with registered data.
// Depends on sas_pkg for the entry type.
module sas_frame_mem #(
  parameter int DEPTH = sas_pkg::TRACKS_DEF * sas_pkg::FRAMES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  sas_pkg::frame_entry_t wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output sas_pkg::frame_entry_t rd_data_r
);
  import sas_pkg::*;

  frame_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/sprite_animation_sequencer.sv
// Top level of the sprite animation sequencer: request decode, per-track
// sequencing and report register. Depends on sas_pkg, sas_if, sas_frame_mem.
//
//   channel  | dir | handshake   | carries
//   ---------+-----+-------------+---------------------------------------------
//   in_ch    | in  | valid/ready | kind, track, index and a frame entry
//   out_ch   | out | valid/ready | one report per track on each tick
//   cfg_ch   | in  | valid/ready | track_count, always ready
//
// Write, clear and empty ticks finish in the idle state; a start adds ST_START
// (one table read). A tick walks each track through ST_RD and ST_REP, and
// through ST_ADV for a track that advances: each track costs a table read
// of its current frame (skipped for a finished track) and, when it advances,
// a read of the new frame, all through the single read port of the frame
// memory.
// Reset (rst_n low, synchronous) clears all track state, the trigger bits
// and the track count; the frame memory is not cleared. A stalled report
// holds the sequencer in place; the report register lets the last report of
// a tick wait while the next request is taken.
module sprite_animation_sequencer #(
  parameter int TRACKS           = sas_pkg::TRACKS_DEF,
  parameter int FRAMES_PER_TRACK = sas_pkg::FRAMES_DEF,
  parameter int END_HOLD_TICKS   = sas_pkg::END_HOLD_DEF
) (
  input  logic clk,
  input  logic rst_n,
  sas_in_if.sink    in_ch,
  sas_out_if.source out_ch,
  sas_cfg_if.sink   cfg_ch
);
  import sas_pkg::*;

  localparam int DEPTH = TRACKS * FRAMES_PER_TRACK;
  localparam int AW    = $clog2(DEPTH);
  localparam int TIW   = (TRACKS > 1) ? $clog2(TRACKS) : 1;

  // Table address of a frame of a track.
  function automatic logic [AW-1:0] slot_addr(input logic [TIW-1:0] t,
                                              input logic [LEN_W-1:0] f);
    slot_addr = AW'(AW'(t) * AW'(FRAMES_PER_TRACK) + AW'(f));
  endfunction

  // Control state.
  state_t         state_r, state_nxt;
  logic [4:0]     count_r;
  logic [TIW-1:0] trk_r, trk_nxt;
  logic           running_r, running_nxt;
  logic [TRIG_W-1:0] trig_r, trig_nxt;
  track_t         tracks_r [TRACKS];

  // Values carried from one step of a track to the next.
  logic [TIW-1:0]   lat_t_r, lat_t_nxt;
  logic [LEN_W-1:0] lat_len_r, lat_len_nxt;
  logic [LEN_W-1:0] b_r, b_nxt;
  logic             clamp_r, clamp_nxt;

  // Report register.
  logic        out_valid_r, out_valid_nxt;
  logic [4:0]  out_track_r, out_track_nxt;
  logic [7:0]  out_image_r, out_image_nxt;
  logic [15:0] out_x_r, out_x_nxt;
  logic [15:0] out_y_r, out_y_nxt;
  logic        out_vis_r, out_vis_nxt;
  logic        out_run_r, out_run_nxt;
  logic        out_last_r, out_last_nxt;

  // Memory access and track write.
  logic         mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  frame_entry_t mem_wdata, ent;
  logic         tr_we, clr_all;
  logic [TIW-1:0] tr_idx;
  track_t       tr_wdata, cur;

  // Decode.
  logic           in_acc, t_ok, idx_ok, out_free, vis, is_last, trig_a, blocked, adv_go;
  logic [5:0]     n_eff;
  logic [LEN_W-1:0] b_raw;
  logic [7:0]     lc1;
  kind_t          kind;

  sas_frame_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk       (clk),
    .wr_en     (mem_we),
    .wr_addr   (mem_waddr),
    .wr_data   (mem_wdata),
    .rd_en     (mem_re),
    .rd_addr   (mem_raddr),
    .rd_data_r (ent)
  );

  assign kind = kind_t'(in_ch.kind);

  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    cfg_ch.ready = 1'b1;
    out_ch.valid = out_valid_r;
    out_ch.track_out = out_track_r;
    out_ch.image_out = out_image_r;
    out_ch.offset_x = out_x_r;
    out_ch.offset_y = out_y_r;
    out_ch.visible = out_vis_r;
    out_ch.any_running = out_run_r;
    out_ch.last = out_last_r;
  end

  // Shared decisions for the sequencer and the datapath.
  always_comb begin
    in_acc   = in_ch.valid && (state_r == ST_IDLE);
    t_ok     = (6'(in_ch.track) < 6'(TRACKS));
    idx_ok   = (LEN_W'(in_ch.index) < LEN_W'(FRAMES_PER_TRACK));
    n_eff    = (6'(count_r) > 6'(TRACKS)) ? 6'(TRACKS) : 6'(count_r);
    cur      = tracks_r[(state_r == ST_START) ? lat_t_r : trk_r];
    out_free = !out_valid_r || out_ch.ready;
    vis      = (LEN_W'(cur.frame) < cur.len);
    is_last  = (6'(trk_r) + 6'd1 == n_eff);
    // Tracks 16 and up have no trigger bit.
    trig_a   = (6'(trk_r) < 6'(TRIG_W)) && trig_r[4'(trk_r)];
    blocked  = (ent.flags[FLAG_WAIT_BIT] && !trig_a) || ent.flags[FLAG_HALT_BIT];
    adv_go   = (cur.wait_cnt == 8'd0) && vis && !blocked;
    lc1      = cur.loop_cnt + 8'd1;
    if (ent.loop_enable && (lc1 < ent.loop_count)) begin
      b_raw = LEN_W'(ent.loop_target);
    end else begin
      b_raw = LEN_W'(cur.frame) + LEN_W'(1);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (kind == KIND_START && t_ok) begin
            state_nxt = ST_START;
          end else if (kind == KIND_TICK && n_eff != 6'd0) begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_START: state_nxt = ST_IDLE;
      ST_RD:    state_nxt = ST_REP;
      ST_REP: begin
        if (out_free) begin
          if (adv_go) begin
            state_nxt = ST_ADV;
          end else begin
            state_nxt = is_last ? ST_IDLE : ST_RD;
          end
        end
      end
      ST_ADV:   state_nxt = is_last ? ST_IDLE : ST_RD;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory requests.
  always_comb begin
    trk_nxt = trk_r;
    running_nxt = running_r;
    trig_nxt = trig_r;
    lat_t_nxt = lat_t_r;
    lat_len_nxt = lat_len_r;
    b_nxt = b_r;
    clamp_nxt = clamp_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_track_nxt = out_track_r;
    out_image_nxt = out_image_r;
    out_x_nxt = out_x_r;
    out_y_nxt = out_y_r;
    out_vis_nxt = out_vis_r;
    out_run_nxt = out_run_r;
    out_last_nxt = out_last_r;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_waddr = slot_addr(TIW'(in_ch.track), LEN_W'(in_ch.index));
    mem_raddr = slot_addr(trk_r, LEN_W'(cur.frame));
    mem_wdata = '{trig_set: in_ch.trig_set, move_y: in_ch.move_y,
                  move_x: in_ch.move_x, loop_target: in_ch.loop_target,
                  loop_count: in_ch.loop_count, loop_enable: in_ch.loop_enable,
                  flags: in_ch.flags, delay: in_ch.delay, image: in_ch.image};
    tr_we = 1'b0;
    clr_all = 1'b0;
    tr_idx = trk_r;
    tr_wdata = cur;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (kind)
            KIND_WRITE: mem_we = t_ok && idx_ok;
            KIND_START: begin
              mem_re = t_ok;
              mem_raddr = slot_addr(TIW'(in_ch.track), LEN_W'(0));
              lat_t_nxt = TIW'(in_ch.track);
              lat_len_nxt = idx_ok ? LEN_W'(in_ch.index) : LEN_W'(FRAMES_PER_TRACK);
            end
            KIND_TICK: begin
              trk_nxt = '0;
              running_nxt = 1'b0;
            end
            KIND_CLEAR: clr_all = 1'b1;
            default: clr_all = 1'b0;
          endcase
        end
      end
      ST_START: begin
        tr_we = 1'b1;
        tr_idx = lat_t_r;
        tr_wdata = '{frame: 8'd0, len: lat_len_r, loop_cnt: 8'd0, wait_cnt: ent.delay,
                     pos_x: ent.move_x, pos_y: ent.move_y};
        trig_nxt = trig_r | ent.trig_set;
      end
      // A finished track reads no entry; its report shows image zero.
      ST_RD: mem_re = vis;
      ST_REP: begin
        if (out_free) begin
          // The report shows the state before this track advances.
          out_valid_nxt = 1'b1;
          out_track_nxt = 5'(trk_r);
          out_image_nxt = vis ? ent.image : 8'd0;
          out_x_nxt = cur.pos_x;
          out_y_nxt = cur.pos_y;
          out_vis_nxt = vis;
          running_nxt = running_r || (LEN_W'(cur.frame) + LEN_W'(1) < cur.len);
          out_run_nxt = is_last && running_nxt;
          out_last_nxt = is_last;
          if (cur.wait_cnt != 8'd0) begin
            tr_we = 1'b1;
            tr_wdata.wait_cnt = cur.wait_cnt - 8'd1;
          end else if (adv_go) begin
            if (ent.loop_enable) begin
              tr_we = 1'b1;
              tr_wdata.loop_cnt = (lc1 < ent.loop_count) ? lc1 : 8'd0;
            end
            // Jumping at or past the end clamps to the last frame; ST_ADV stays there only if its hold flag is set.
            clamp_nxt = (b_raw >= cur.len);
            b_nxt = clamp_nxt ? cur.len - LEN_W'(1) : b_raw;
            mem_re = 1'b1;
            mem_raddr = slot_addr(trk_r, b_nxt);
          end
          if (!adv_go && !is_last) begin
            trk_nxt = trk_r + TIW'(1);
          end
        end
      end
      ST_ADV: begin
        tr_we = 1'b1;
        if (clamp_r) begin
          tr_wdata.wait_cnt = 8'(END_HOLD_TICKS);
          tr_wdata.frame = ent.flags[FLAG_HOLD_BIT] ? b_r[7:0] : 8'(b_r + LEN_W'(1));
        end else begin
          tr_wdata.frame = b_r[7:0];
          tr_wdata.wait_cnt = ent.delay;
          tr_wdata.pos_x = (ent.flags[FLAG_RESET_X_BIT] ? 16'd0 : cur.pos_x) + ent.move_x;
          tr_wdata.pos_y = (ent.flags[FLAG_RESET_Y_BIT] ? 16'd0 : cur.pos_y) + ent.move_y;
          trig_nxt = trig_r;
          if (6'(trk_r) < 6'(TRIG_W)) begin
            trig_nxt[4'(trk_r)] = 1'b0;
          end
          trig_nxt = trig_nxt | ent.trig_set;
        end
        if (!is_last) begin
          trk_nxt = trk_r + TIW'(1);
        end
      end
      default: tr_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      trk_r <= '0;
      running_r <= 1'b0;
      trig_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TRACKS; i++) begin
        tracks_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      trk_r <= trk_nxt;
      running_r <= running_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        count_r <= cfg_ch.data;
      end
      if (clr_all) begin
        trig_r <= '0;
        for (int i = 0; i < TRACKS; i++) begin
          tracks_r[i] <= '0;
        end
      end else begin
        trig_r <= trig_nxt;
        if (tr_we) begin
          tracks_r[tr_idx] <= tr_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    lat_t_r <= lat_t_nxt;
    lat_len_r <= lat_len_nxt;
    b_r <= b_nxt;
    clamp_r <= clamp_nxt;
    out_track_r <= out_track_nxt;
    out_image_r <= out_image_nxt;
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
    out_vis_r <= out_vis_nxt;
    out_run_r <= out_run_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// File: hw/rtl/sas_checker.sv
// Port checker of the sprite animation sequencer and its bind statement.
// Depends on the top level's report port.
module sas_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_image,
  input logic       out_visible,
  input logic       out_any_running,
  input logic       out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("report dropped while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("report shown after reset");

  a_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !out_any_running)
    else $error("running flag on a report that is not the last");

  a_image: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |-> out_image == 8'd0)
    else $error("image shown for a track that is not visible");

endmodule

bind sprite_animation_sequencer sas_checker u_sas_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_image       (out_ch.image_out),
  .out_visible     (out_ch.visible),
  .out_any_running (out_ch.any_running),
  .out_last        (out_ch.last)
);

// File: tb/tb.sv
// Self-checking testbench of sprite_animation_sequencer: a directed table of
// requests followed by random frame scripts, ticks and noise, all checked
// against an in-bench predictor. Depends on sas_pkg and sas_if.
`timescale 1ns / 1ps

module tb;
  import sas_pkg::*;

  localparam int NTRK      = 32;
  localparam int NFRM      = 256;
  localparam int HOLD      = 10;
  localparam int DRAIN     = 4 * NTRK + 20;
  localparam int WD_LIMIT  = 20000;
  localparam int PHASE_REQ = 44;

  typedef struct {
    kind_t        kind;
    logic [4:0]   track;
    logic [7:0]   index;
    frame_entry_t e;
    bit           known;   // a tick whose reports are typed in, not predicted
  } req_t;

  typedef struct packed {
    logic [4:0]  trk;
    logic [7:0]  img;
    logic [15:0] x;
    logic [15:0] y;
    logic        vis;
    logic        run;
    logic        last;
  } report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sas_in_if  in_ch ();
  sas_out_if out_ch ();
  sas_cfg_if cfg_ch ();

  sprite_animation_sequencer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the sequencer: frame tables, per-track state, trigger bits and
  // the track count register.
  frame_entry_t frame_tab [NTRK][NFRM];
  bit           loaded [NTRK][NFRM];
  int unsigned  cur_frame [NTRK];
  int unsigned  trk_len [NTRK];
  logic [7:0]   loop_cnt [NTRK];
  logic [7:0]   wait_cnt [NTRK];
  logic [15:0]  pos_x [NTRK];
  logic [15:0]  pos_y [NTRK];
  logic [15:0]  trig_bits;
  int unsigned  track_cnt;

  report_t pending_reports [$];
  int      errors = 0;
  int      idle_in_pct = 0;
  int      stall_out_pct = 0;
  bit      any_accept;

  task automatic report_error(input string what, input logic [31:0] exp_v,
                              input logic [31:0] got_v);
    $display("[%0t] mismatch %s: expected %0h, got %0h", $realtime, what, exp_v, got_v);
    errors++;
  endtask

  function automatic void clear_tracks();
    for (int a = 0; a < NTRK; a++) begin
      cur_frame[a] = 0;
      trk_len[a]   = 0;
      loop_cnt[a]  = '0;
      wait_cnt[a]  = '0;
      pos_x[a]     = '0;
      pos_y[a]     = '0;
    end
    trig_bits = '0;
  endfunction

  // One track's step at the end of a tick: delay, trigger wait, halt, counted
  // loop, then either the end of the script or entry into a new frame.
  function automatic void advance_track(int a);
    int unsigned  f, len, b;
    logic [7:0]   fl;
    bit           trig;
    frame_entry_t e;
    if (wait_cnt[a] != 0) begin
      wait_cnt[a]--;
      return;
    end
    f   = cur_frame[a];
    len = trk_len[a];
    if (f >= len) return;
    e    = frame_tab[a][f];
    fl   = e.flags;
    trig = (a < 16) && trig_bits[a];
    if ((fl[FLAG_WAIT_BIT] && !trig) || fl[FLAG_HALT_BIT]) return;
    if (e.loop_enable) begin
      loop_cnt[a] = loop_cnt[a] + 8'd1;
      if (loop_cnt[a] < e.loop_count) begin
        b = e.loop_target;
      end else begin
        b = f + 1;
        loop_cnt[a] = '0;
      end
    end else begin
      b = f + 1;
    end
    if (b >= len) begin
      b = len - 1;
      wait_cnt[a]  = 8'(HOLD);
      cur_frame[a] = frame_tab[a][b].flags[FLAG_HOLD_BIT] ? b : b + 1;
    end else begin
      e = frame_tab[a][b];
      cur_frame[a] = b;
      wait_cnt[a]  = e.delay;
      if (e.flags[FLAG_RESET_X_BIT]) pos_x[a] = '0;
      if (e.flags[FLAG_RESET_Y_BIT]) pos_y[a] = '0;
      pos_x[a] = pos_x[a] + e.move_x;
      pos_y[a] = pos_y[a] + e.move_y;
      if (a < 16) trig_bits[a] = 1'b0;
      trig_bits = trig_bits | e.trig_set;
    end
  endfunction

  // Apply one accepted request to the shadow and queue the reports it causes.
  function automatic void predict_request(req_t r);
    int      t;
    bit      running;
    report_t rep;
    t = r.track;
    case (r.kind)
      KIND_WRITE: begin
        frame_tab[t][r.index] = r.e;
        loaded[t][r.index]    = 1'b1;
      end
      KIND_START: begin
        trk_len[t]   = r.index;
        cur_frame[t] = 0;
        loop_cnt[t]  = '0;
        pos_x[t]     = frame_tab[t][0].move_x;
        pos_y[t]     = frame_tab[t][0].move_y;
        wait_cnt[t]  = frame_tab[t][0].delay;
        trig_bits    = trig_bits | frame_tab[t][0].trig_set;
      end
      KIND_CLEAR: clear_tracks();
      default: begin
        if (track_cnt == 0) return;
        running = 1'b0;
        for (int a = 0; a < track_cnt; a++)
          if (cur_frame[a] + 1 < trk_len[a]) running = 1'b1;
        for (int a = 0; a < track_cnt; a++) begin
          rep.trk  = a[4:0];
          rep.last = (a + 1 == track_cnt);
          if (r.known) begin
            // Right after reset every track is empty: nothing shows.
            rep.img = '0; rep.x = '0; rep.y = '0; rep.vis = 1'b0; rep.run = 1'b0;
          end else begin
            rep.vis = cur_frame[a] < trk_len[a];
            rep.img = rep.vis ? frame_tab[a][cur_frame[a]].image : 8'd0;
            rep.x   = pos_x[a];
            rep.y   = pos_y[a];
            rep.run = rep.last ? running : 1'b0;
          end
          pending_reports.push_back(rep);
        end
        for (int a = 0; a < track_cnt; a++) advance_track(a);
      end
    endcase
  endfunction

  // Present one request at the falling edge, with random idle cycles first,
  // and update the shadow at the edge that accepts it.
  task automatic send_request(req_t r);
    @(negedge clk);
    while (($urandom % 100) < idle_in_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= r.kind;
    in_ch.track        <= r.track;
    in_ch.index        <= r.index;
    in_ch.image        <= r.e.image;
    in_ch.delay        <= r.e.delay;
    in_ch.flags        <= r.e.flags;
    in_ch.move_x       <= r.e.move_x;
    in_ch.move_y       <= r.e.move_y;
    in_ch.loop_enable  <= r.e.loop_enable;
    in_ch.loop_count   <= r.e.loop_count;
    in_ch.loop_target  <= r.e.loop_target;
    in_ch.trig_set     <= r.e.trig_set;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_request(r);
  endtask

  // Lower valid, wait for every report, then let a possible last request
  // finish inside the block.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending_reports.size() == 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_track_count(int unsigned n);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= n[4:0];
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    track_cnt = n;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic req_t mk(kind_t k, int t, int idx, int img, int dly, int fl,
                              int mx, int my, int le, int lc, int lt, int mask);
    req_t r;
    r.kind = k; r.track = 5'(t); r.index = 8'(idx); r.known = 1'b0;
    r.e.image = 8'(img); r.e.delay = 8'(dly); r.e.flags = 8'(fl);
    r.e.move_x = 16'(mx); r.e.move_y = 16'(my); r.e.loop_enable = 1'(le);
    r.e.loop_count = 8'(lc); r.e.loop_target = 8'(lt); r.e.trig_set = 16'(mask);
    return r;
  endfunction

  function automatic req_t tick_req();
    return mk(KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
  endfunction

  // A frame entry of a well-formed script of len frames: short delays so
  // the script moves, occasional waits, halts and loops.
  function automatic req_t script_entry(int t, int i, int len);
    req_t r;
    int   fl;
    fl = $urandom % 8;
    if (($urandom % 100) < 20) fl |= 8'h08;
    if (($urandom % 100) < 5)  fl |= 8'h10;
    if (($urandom % 100) < 30) fl |= 8'h20;
    if (($urandom % 100) < 30) fl |= 8'h40;
    if (($urandom % 100) < 30) fl |= 8'h80;
    r = mk(KIND_WRITE, t, i, $urandom % 256,
           (($urandom % 20) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 2), fl,
           $urandom % 65536, $urandom % 65536, ($urandom % 4) == 0, $urandom % 4,
           (($urandom % 10) == 0) ? $urandom % 256 : $urandom_range(0, len),
           (($urandom % 2) == 0) ? 0 : $urandom % 65536);
    return r;
  endfunction

  function automatic int loaded_prefix(int t);
    int p = 0;
    while (p < NFRM && loaded[t][p]) p++;
    return p;
  endfunction

  always @(negedge clk)
    out_ch.ready <= (($urandom % 100) >= stall_out_pct);

  // Compare every accepted report with the oldest expectation.
  always @(posedge clk) begin
    report_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        report_error("unexpected report, track", 32'hx, out_ch.track_out);
      end else begin
        exp_r = pending_reports.pop_front();
        if (out_ch.track_out !== exp_r.trk) report_error("track_out", exp_r.trk, out_ch.track_out);
        if (out_ch.image_out !== exp_r.img) report_error("image_out", exp_r.img, out_ch.image_out);
        if (out_ch.offset_x !== exp_r.x) report_error("offset_x", exp_r.x, out_ch.offset_x);
        if (out_ch.offset_y !== exp_r.y) report_error("offset_y", exp_r.y, out_ch.offset_y);
        if (out_ch.visible !== exp_r.vis) report_error("visible", exp_r.vis, out_ch.visible);
        if (out_ch.any_running !== exp_r.run)
          report_error("any_running", exp_r.run, out_ch.any_running);
        if (out_ch.last !== exp_r.last) report_error("last", exp_r.last, out_ch.last);
      end
    end
  end

  // Watchdog on cycles in which no channel moves anything.
  always @(posedge clk) begin
    int unsigned quiet;
    any_accept = (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready);
    if (!rst_n || any_accept) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WD_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    req_t        dir_tab [$];
    req_t        r;
    int          counts [8] = '{31, 0, 17, 1, 16, 5, 31, 2};
    int          sent, t, len, p, sel;

    in_ch.valid = 1'b0; in_ch.kind = KIND_WRITE; in_ch.track = '0; in_ch.index = '0;
    in_ch.image = '0; in_ch.delay = '0; in_ch.flags = '0; in_ch.move_x = '0;
    in_ch.move_y = '0; in_ch.loop_enable = 1'b0; in_ch.loop_count = '0;
    in_ch.loop_target = '0; in_ch.trig_set = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    for (int a = 0; a < NTRK; a++)
      for (int f = 0; f < NFRM; f++) loaded[a][f] = 1'b0;
    clear_tracks();
    track_cnt = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A tick with no tracks configured must report nothing.
    send_request(tick_req());
    settle();
    write_track_count(4);

    // Directed table. The first tick comes straight after reset, so its
    // reports are typed in; the rest go through the predictor.
    r = tick_req(); r.known = 1'b1; dir_tab.push_back(r);
    // Track 0: resets both offsets on entry 0 with extreme moves, waits on
    // its trigger at frame 1, and loops at frame 2 which it holds at the end.
    dir_tab.push_back(mk(KIND_WRITE, 0, 0, 255, 0, 8'hC0, 32767, -32768, 0, 0, 0, 16'h0002));
    dir_tab.push_back(mk(KIND_WRITE, 0, 1, 1, 1, 8'h08, -1, 1, 0, 0, 0, 0));
    dir_tab.push_back(mk(KIND_WRITE, 0, 2, 2, 0, 8'h20, 100, -100, 1, 2, 1, 16'hFFFF));
    // Track 1 fires the trigger of track 0, then sits on a long delay.
    dir_tab.push_back(mk(KIND_WRITE, 1, 0, 7, 0, 0, 5, 6, 0, 0, 0, 16'h0001));
    dir_tab.push_back(mk(KIND_WRITE, 1, 1, 8, 255, 0, -32768, 32767, 0, 0, 0, 0));
    dir_tab.push_back(mk(KIND_START, 1, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(KIND_START, 0, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Track 2 is halted on frame 0 with the longest length.
    dir_tab.push_back(mk(KIND_WRITE, 2, 0, 8'h5A, 2, 8'h10, 3, 4, 0, 0, 0, 0));
    dir_tab.push_back(mk(KIND_START, 2, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Track 3: all-ones entries, started with length zero.
    dir_tab.push_back(mk(KIND_WRITE, 3, 0, 255, 255, 255, -1, -1, 1, 255, 255, 16'hFFFF));
    dir_tab.push_back(mk(KIND_WRITE, 3, 255, 255, 255, 255, -1, -1, 1, 255, 255, 16'hFFFF));
    dir_tab.push_back(mk(KIND_START, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Highest track number, which no tick ever reaches.
    dir_tab.push_back(mk(KIND_WRITE, 31, 0, 9, 0, 8'h08, 1, 1, 0, 0, 0, 16'h8000));
    dir_tab.push_back(mk(KIND_START, 31, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 6; i++) dir_tab.push_back(tick_req());
    dir_tab.push_back(mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(tick_req());
    foreach (dir_tab[i]) send_request(dir_tab[i]);
    settle();

    // Random phases: each phase sets a track count and an idling pattern.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_in_pct = 0;  stall_out_pct = 0;  end
        1: begin idle_in_pct = 69; stall_out_pct = 0;  end
        2: begin idle_in_pct = 0;  stall_out_pct = 69; end
        default: begin idle_in_pct = 29; stall_out_pct = 29; end
      endcase
      write_track_count(counts[ph]);
      sent = 0;
      while (sent < PHASE_REQ) begin
        sel = $urandom % 100;
        if (sel < 20) begin
          // Well-formed script: load the frames, then start the track.
          t = ($urandom % 4 != 0 && track_cnt > 0) ? $urandom % track_cnt : $urandom % NTRK;
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) send_request(script_entry(t, i, len));
          send_request(mk(KIND_START, t, len, 0, 0, 0, 0, 0, 0, 0, 0, 0));
          sent += len + 1;
        end else if (sel < 25) begin
          send_request(mk(KIND_WRITE, $urandom % NTRK, $urandom % NFRM, $urandom % 256,
                          $urandom % 256, $urandom % 256, $urandom % 65536,
                          $urandom % 65536, $urandom % 2, $urandom % 256,
                          $urandom % 256, $urandom % 65536));
          sent++;
        end else if (sel < 30) begin
          // Restart only where every frame it can reach is loaded.
          t = $urandom % NTRK;
          p = loaded_prefix(t);
          if (p > 0) begin
            len = $urandom_range(0, p);
            send_request(mk(KIND_START, t, len, 0, 0, 0, 0, 0, 0, 0, 0, 0));
            sent++;
          end
        end else if (sel < 33) begin
          send_request(mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
          sent++;
        end else begin
          send_request(tick_req());
          sent++;
        end
      end
      settle();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
